[rtl/gfv_pkg.sv]
package gfv_pkg;

  // Mesh dimensionality: 3 uses every gradient, 2 drops the z terms
  localparam int DIMENSIONS = 3;
  localparam bit THREE_D    = (DIMENSIONS == 3);

  // Field widths
  localparam int GRAD_W = 48;
  localparam int P_W    = 47;
  localparam int FRAC_W = 16;
  localparam int SIN_W  = 17;

  // Shear path widths
  localparam int D_W     = GRAD_W + 3;   // 2*a - b - c
  localparam int X_W     = GRAD_W + 1;   // a + b
  localparam int MAG_W   = 50;
  localparam int HALF_W  = 25;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int W_SHIFT = 25;
  localparam int W_W     = SUM_W + W_SHIFT;
  localparam int ROOT_W  = 64;

  // Frictional pressure widths
  localparam int AN_W   = 2 * FRAC_W;
  localparam int NUM_W  = 3 * FRAC_W;
  localparam int D4_W   = 4 * FRAC_W;
  localparam int D5_W   = 5 * FRAC_W;
  localparam int PDEN_W = D5_W + 4;
  localparam int PREM_W = PDEN_W + 1;

  // Viscosity divider widths
  localparam int Q_W  = P_W;
  localparam int PS_W = P_W + SIN_W;
  localparam int N_W  = PS_W + 14;
  localparam int NHI_W = N_W - Q_W;

  // Pipeline depth: front, root, divider setup, divider, output
  localparam int FRONT_STG = 6;
  localparam int N_STG     = FRONT_STG + ROOT_W + 3 + Q_W + 1;

  localparam logic [P_W-1:0] P_MAX = '1;

  // Register reset values
  localparam logic [FRAC_W-1:0] FRICTION_FRACTION_RST  = 16'd39321;
  localparam logic [FRAC_W-1:0] PACKING_FRACTION_RST   = 16'd41943;
  localparam logic [SIN_W-1:0]  SIN_FRICTION_ANGLE_RST = 17'd32768;
  localparam logic [P_W-1:0]    VISCOSITY_LIMIT_RST    = 47'd6553600000;

  typedef enum logic [1:0] {
    CFG_FRICTION_FRACTION  = 2'd0,
    CFG_PACKING_FRACTION   = 2'd1,
    CFG_SIN_FRICTION_ANGLE = 2'd2,
    CFG_VISCOSITY_LIMIT    = 2'd3
  } cfg_idx_t;

endpackage

[rtl/gfv_cell_if.sv]
interface gfv_cell_if;
  import gfv_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] du_dx;
  logic signed [GRAD_W-1:0] du_dy;
  logic signed [GRAD_W-1:0] du_dz;
  logic signed [GRAD_W-1:0] dv_dx;
  logic signed [GRAD_W-1:0] dv_dy;
  logic signed [GRAD_W-1:0] dv_dz;
  logic signed [GRAD_W-1:0] dw_dx;
  logic signed [GRAD_W-1:0] dw_dy;
  logic signed [GRAD_W-1:0] dw_dz;
  logic [P_W-1:0]           granular_pressure;
  logic [FRAC_W-1:0]        solid_fraction;

  modport source (
    output valid, du_dx, du_dy, du_dz, dv_dx, dv_dy, dv_dz, dw_dx, dw_dy, dw_dz,
    output granular_pressure, solid_fraction,
    input  ready
  );

  modport sink (
    input  valid, du_dx, du_dy, du_dz, dv_dx, dv_dy, dv_dz, dw_dx, dw_dy, dw_dz,
    input  granular_pressure, solid_fraction,
    output ready
  );

endinterface

[rtl/gfv_visc_if.sv]
interface gfv_visc_if;
  import gfv_pkg::*;

  logic           valid;
  logic           ready;
  logic [P_W-1:0] friction_viscosity;
  logic           was_limited;

  modport source (output valid, friction_viscosity, was_limited, input ready);
  modport sink (input valid, friction_viscosity, was_limited, output ready);

endinterface

[rtl/granular_friction_viscosity_top.sv]
// Frictional viscosity pipeline, one mesh cell per beat. A cell beat is taken
// every cycle while the result side takes beats; the result of a cell passes
// through 121 register stages, the first loaded by the edge that took it. The
// depth is mostly set by the 64-stage bit-per-stage square root of the shear
// term, followed by a 47-stage restoring divider for p*sin(phi)/shear; the
// 47-step pressure divider runs beside the root. When a finished result is not
// taken the whole pipeline holds and the cell side drops ready. Configuration
// writes take effect at once and are meant to be issued while no cell is in
// flight.
module granular_friction_viscosity_top (
  input  logic                      clk,
  input  logic                      rst,
  gfv_cell_if.sink                  grad,
  gfv_visc_if.source                visc,
  input  logic                      cfg_we,
  input  gfv_pkg::cfg_idx_t         cfg_index,
  input  logic [gfv_pkg::P_W-1:0]   cfg_data
);
  import gfv_pkg::*;

  // ---------------------------------------------------------------- config
  logic [FRAC_W-1:0] friction_fraction;
  logic [FRAC_W-1:0] packing_fraction;
  logic [SIN_W-1:0]  sin_friction_angle;
  logic [P_W-1:0]    viscosity_limit;

  // Write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      friction_fraction  <= FRICTION_FRACTION_RST;
      packing_fraction   <= PACKING_FRACTION_RST;
      sin_friction_angle <= SIN_FRICTION_ANGLE_RST;
      viscosity_limit    <= VISCOSITY_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRICTION_FRACTION:  friction_fraction  <= cfg_data[FRAC_W-1:0];
        CFG_PACKING_FRACTION:   packing_fraction   <= cfg_data[FRAC_W-1:0];
        CFG_SIN_FRICTION_ANGLE: sin_friction_angle <= cfg_data[SIN_W-1:0];
        CFG_VISCOSITY_LIMIT:    viscosity_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  logic             adv;
  logic [N_STG-1:0] vld;

  assign adv        = !vld[N_STG-1] || visc.ready;
  assign grad.ready = adv;

  // Advance occupancy with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[N_STG-2:0], grad.valid};
    end
  end

  // ---------------------------------------------------------------- stage A
  logic signed [GRAD_W-1:0] uz_g, vz_g, wx_g, wy_g, wz_g;
  logic signed [D_W-1:0]    d_term [3];
  logic signed [X_W-1:0]    x_term [3];

  assign uz_g = THREE_D ? grad.du_dz : '0;
  assign vz_g = THREE_D ? grad.dv_dz : '0;
  assign wx_g = THREE_D ? grad.dw_dx : '0;
  assign wy_g = THREE_D ? grad.dw_dy : '0;
  assign wz_g = THREE_D ? grad.dw_dz : '0;

  // Form deviatoric diagonal and cross sums
  always_comb begin
    d_term[0] = (D_W'(grad.du_dx) <<< 1) - D_W'(grad.dv_dy) - D_W'(wz_g);
    d_term[1] = (D_W'(grad.dv_dy) <<< 1) - D_W'(grad.du_dx) - D_W'(wz_g);
    d_term[2] = THREE_D ? ((D_W'(wz_g) <<< 1) - D_W'(grad.du_dx) - D_W'(grad.dv_dy))
                        : '0;
    x_term[0] = X_W'(uz_g) + X_W'(wx_g);
    x_term[1] = X_W'(grad.du_dy) + X_W'(grad.dv_dx);
    x_term[2] = X_W'(wy_g) + X_W'(vz_g);
  end

  logic signed [D_W-1:0] a_d [3];
  logic signed [X_W-1:0] a_x [3];
  logic [P_W-1:0]        a_pg;
  logic                  a_act, a_psat;
  logic [FRAC_W-1:0]     a_frac, a_numf, a_gap;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_d    <= d_term;
      a_x    <= x_term;
      a_pg   <= grad.granular_pressure;
      a_act  <= grad.solid_fraction > friction_fraction;
      a_psat <= grad.solid_fraction >= packing_fraction;
      a_frac <= grad.solid_fraction;
      a_numf <= grad.solid_fraction - friction_fraction;
      a_gap  <= packing_fraction - grad.solid_fraction;
    end
  end

  // ---------------------------------------------------------------- stage B
  logic [D_W-1:0] d_abs [3];
  logic [X_W-1:0] x_abs [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_abs[k] = a_d[k][D_W-1] ? -a_d[k] : a_d[k];
      x_abs[k] = a_x[k][X_W-1] ? -a_x[k] : a_x[k];
    end
  end

  logic [MAG_W-1:0]  b_mag [6];
  logic [AN_W-1:0]   b_an, b_dd;
  logic [FRAC_W-1:0] b_numf, b_gap;
  logic [P_W-1:0]    b_pg;
  logic              b_act, b_psat;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        b_mag[k]   <= d_abs[k][MAG_W-1:0];
        b_mag[k+3] <= {1'b0, x_abs[k]};
      end
      b_an   <= AN_W'(a_frac) * AN_W'(a_numf);
      b_dd   <= AN_W'(a_gap) * AN_W'(a_gap);
      b_numf <= a_numf;
      b_gap  <= a_gap;
      b_pg   <= a_pg;
      b_act  <= a_act;
      b_psat <= a_psat;
    end
  end

  // ---------------------------------------------------------------- stage C
  // Square each magnitude as three half-width partial products
  logic [MAG_W-1:0]  c_hh [6];
  logic [MAG_W-1:0]  c_hl [6];
  logic [MAG_W-1:0]  c_ll [6];
  logic [NUM_W-1:0]  c_num;
  logic [D4_W-1:0]   c_d4;
  logic [FRAC_W-1:0] c_gap;
  logic [P_W-1:0]    c_pg;
  logic              c_act, c_psat;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        c_hh[k] <= MAG_W'(b_mag[k][MAG_W-1:HALF_W]) * MAG_W'(b_mag[k][MAG_W-1:HALF_W]);
        c_hl[k] <= MAG_W'(b_mag[k][MAG_W-1:HALF_W]) * MAG_W'(b_mag[k][HALF_W-1:0]);
        c_ll[k] <= MAG_W'(b_mag[k][HALF_W-1:0]) * MAG_W'(b_mag[k][HALF_W-1:0]);
      end
      c_num  <= NUM_W'(b_an) * NUM_W'(b_numf);
      c_d4   <= D4_W'(b_dd) * D4_W'(b_dd);
      c_gap  <= b_gap;
      c_pg   <= b_pg;
      c_act  <= b_act;
      c_psat <= b_psat;
    end
  end

  // ---------------------------------------------------------------- stage D
  logic [SQ_W-1:0]  d_sq [6];
  logic [D5_W-1:0]  d_d5;
  logic [NUM_W-1:0] d_num;
  logic [P_W-1:0]   d_pg;
  logic             d_act, d_psat;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        d_sq[k] <= (SQ_W'(c_hh[k]) << (2 * HALF_W)) + (SQ_W'(c_hl[k]) << (HALF_W + 1))
                 + SQ_W'(c_ll[k]);
      end
      d_d5   <= D5_W'(c_d4) * D5_W'(c_gap);
      d_num  <= c_num;
      d_pg   <= c_pg;
      d_act  <= c_act;
      d_psat <= c_psat;
    end
  end

  // ---------------------------------------------------------------- stage E
  logic [SUM_W-1:0]  e_dsum, e_xsum;
  logic [PDEN_W-1:0] e_dp;
  logic [NUM_W-1:0]  e_num;
  logic [P_W-1:0]    e_pg;
  logic              e_act, e_psat;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_dsum <= SUM_W'(d_sq[0]) + SUM_W'(d_sq[1]) + SUM_W'(d_sq[2]);
      e_xsum <= SUM_W'(d_sq[3]) + SUM_W'(d_sq[4]) + SUM_W'(d_sq[5]);
      e_dp   <= (PDEN_W'(d_d5) << 3) + (PDEN_W'(d_d5) << 1);
      e_num  <= d_num;
      e_pg   <= d_pg;
      e_act  <= d_act;
      e_psat <= d_psat;
    end
  end

  // ---------------------------------------------------------------- stage F
  logic [SUM_W:0]    w_sum;
  logic [W_W-1:0]    f_w;
  logic [PDEN_W-1:0] f_dp;
  logic [NUM_W-1:0]  f_num;
  logic [P_W-1:0]    f_pg;
  logic              f_act, f_psat;

  // Weight diagonal by two and cross terms by nine
  assign w_sum = ((SUM_W+1)'(e_dsum) << 1) + ((SUM_W+1)'(e_xsum) << 3)
               + (SUM_W+1)'(e_xsum);

  always_ff @(posedge clk) begin
    if (adv) begin
      f_w    <= {w_sum[SUM_W-1:0], {W_SHIFT{1'b0}}};
      f_dp   <= e_dp;
      f_num  <= e_num;
      f_pg   <= e_pg;
      f_act  <= e_act;
      f_psat <= e_psat;
    end
  end

  // ---------------------------------------------------------------- root
  logic [ROOT_W-1:0] g_root;

  gfv_root u_root (
    .clk  (clk),
    .en   (adv),
    .w    (f_w),
    .root (g_root)
  );

  // ---------------------------------------------------------------- pressure
  // Beside the root: overflow check, then one quotient bit per stage
  logic [PREM_W-1:0] p_rem [1:ROOT_W];
  logic [Q_W-1:0]    p_q   [1:ROOT_W];
  logic [PDEN_W-1:0] p_dp  [1:ROOT_W];
  logic              p_sat [1:ROOT_W];
  logic [P_W-1:0]    p_pg  [1:ROOT_W];
  logic              p_act [1:ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_pres
    logic [PREM_W-1:0] rem_cur, rem_nx;
    logic [Q_W-1:0]    q_cur, q_nx;
    logic [PDEN_W-1:0] dp_cur;
    logic              sat_cur, sat_nx;
    logic [P_W-1:0]    pg_cur;
    logic              act_cur;

    if (j == 0) begin : g_first
      assign rem_cur = PREM_W'({f_num, 1'b0});
      assign q_cur   = '0;
      assign dp_cur  = f_dp;
      assign sat_cur = f_psat;
      assign pg_cur  = f_pg;
      assign act_cur = f_act;
    end else begin : g_next
      assign rem_cur = p_rem[j];
      assign q_cur   = p_q[j];
      assign dp_cur  = p_dp[j];
      assign sat_cur = p_sat[j];
      assign pg_cur  = p_pg[j];
      assign act_cur = p_act[j];
    end

    if (j == 0) begin : g_ovf
      assign rem_nx = rem_cur;
      assign q_nx   = q_cur;
      assign sat_nx = sat_cur | (rem_cur >= PREM_W'(dp_cur));
    end else if (j <= Q_W) begin : g_bit
      logic [PREM_W-1:0] shifted;
      logic              take;
      assign shifted = {rem_cur[PREM_W-2:0], 1'b0};
      assign take    = shifted >= PREM_W'(dp_cur);
      assign rem_nx  = take ? shifted - PREM_W'(dp_cur) : shifted;
      assign q_nx    = {q_cur[Q_W-2:0], take};
      assign sat_nx  = sat_cur;
    end else begin : g_pass
      assign rem_nx = rem_cur;
      assign q_nx   = q_cur;
      assign sat_nx = sat_cur;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        p_rem[j+1] <= rem_nx;
        p_q[j+1]   <= q_nx;
        p_dp[j+1]  <= dp_cur;
        p_sat[j+1] <= sat_nx;
        p_pg[j+1]  <= pg_cur;
        p_act[j+1] <= act_cur;
      end
    end
  end

  // ---------------------------------------------------------------- stage H
  logic [P_W-1:0]    p_fric, p_max;
  logic [PS_W-1:0]   h_ps;
  logic [ROOT_W-1:0] h_root;
  logic              h_act;

  // Pick the larger pressure
  assign p_fric = p_sat[ROOT_W] ? P_MAX : p_q[ROOT_W];
  assign p_max  = (p_pg[ROOT_W] > p_fric) ? p_pg[ROOT_W] : p_fric;

  always_ff @(posedge clk) begin
    if (adv) begin
      h_ps   <= PS_W'(p_max) * PS_W'(sin_friction_angle);
      h_root <= g_root;
      h_act  <= p_act[ROOT_W];
    end
  end

  // ---------------------------------------------------------------- stage I
  logic [N_W-1:0]    i_n;
  logic [ROOT_W-1:0] i_root;
  logic              i_rz, i_act;

  // Scale by 3 * 2^12
  always_ff @(posedge clk) begin
    if (adv) begin
      i_n    <= (N_W'(h_ps) << 13) + (N_W'(h_ps) << 12);
      i_root <= h_root;
      i_rz   <= h_root == '0;
      i_act  <= h_act;
    end
  end

  // ---------------------------------------------------------------- stage J
  logic [ROOT_W-1:0] j_rem, j_root;
  logic [Q_W-1:0]    j_lo;
  logic              j_ovf, j_rz, j_act;

  // Quotient needs more than Q_W bits when the top part reaches the divisor
  always_ff @(posedge clk) begin
    if (adv) begin
      j_rem  <= ROOT_W'(i_n[N_W-1:Q_W]);
      j_ovf  <= ROOT_W'(i_n[N_W-1:Q_W]) >= i_root;
      j_lo   <= i_n[Q_W-1:0];
      j_root <= i_root;
      j_rz   <= i_rz;
      j_act  <= i_act;
    end
  end

  // ---------------------------------------------------------------- divider
  logic [ROOT_W-1:0] v_rem  [1:Q_W];
  logic [ROOT_W-1:0] v_root [1:Q_W];
  logic [Q_W-1:0]    v_q    [1:Q_W];
  logic [Q_W-1:0]    v_lo   [1:Q_W];
  logic              v_ovf  [1:Q_W];
  logic              v_rz   [1:Q_W];
  logic              v_act  [1:Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    logic [ROOT_W-1:0] rem_cur, root_cur;
    logic [Q_W-1:0]    q_cur, lo_cur;
    logic              ovf_cur, rz_cur, act_cur;
    logic [ROOT_W:0]   shifted, diff;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_cur  = j_rem;
      assign root_cur = j_root;
      assign q_cur    = '0;
      assign lo_cur   = j_lo;
      assign ovf_cur  = j_ovf;
      assign rz_cur   = j_rz;
      assign act_cur  = j_act;
    end else begin : g_next
      assign rem_cur  = v_rem[k];
      assign root_cur = v_root[k];
      assign q_cur    = v_q[k];
      assign lo_cur   = v_lo[k];
      assign ovf_cur  = v_ovf[k];
      assign rz_cur   = v_rz[k];
      assign act_cur  = v_act[k];
    end

    // Bring down one dividend bit and try the subtract
    assign shifted = {rem_cur, lo_cur[Q_W-1-k]};
    assign diff    = shifted - {1'b0, root_cur};
    assign take    = shifted >= {1'b0, root_cur};

    always_ff @(posedge clk) begin
      if (adv) begin
        v_rem[k+1]  <= take ? diff[ROOT_W-1:0] : shifted[ROOT_W-1:0];
        v_q[k+1]    <= {q_cur[Q_W-2:0], take};
        v_root[k+1] <= root_cur;
        v_lo[k+1]   <= lo_cur;
        v_ovf[k+1]  <= ovf_cur;
        v_rz[k+1]   <= rz_cur;
        v_act[k+1]  <= act_cur;
      end
    end
  end

  // ---------------------------------------------------------------- output
  logic [P_W-1:0] o_eta;
  logic           o_lim;

  // Clamp to the limit; zero at or below the friction fraction
  always_ff @(posedge clk) begin
    if (adv) begin
      if (!v_act[Q_W]) begin
        o_eta <= '0;
        o_lim <= 1'b0;
      end else if (v_rz[Q_W] || v_ovf[Q_W] || (v_q[Q_W] > viscosity_limit)) begin
        o_eta <= viscosity_limit;
        o_lim <= 1'b1;
      end else begin
        o_eta <= v_q[Q_W];
        o_lim <= 1'b0;
      end
    end
  end

  assign visc.valid              = vld[N_STG-1];
  assign visc.friction_viscosity = o_eta;
  assign visc.was_limited        = o_lim;

`ifndef SYNTHESIS
  // A held result freezes the occupancy of every stage
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && !adv) |=> $stable(vld))
    else $error("pipeline occupancy moved during a stall");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (vld == '0))
    else $error("pipeline not empty after reset");
`endif

endmodule

[rtl/gfv_root.sv]
module gfv_root (
  input  logic                       clk,
  input  logic                       en,
  input  logic [gfv_pkg::W_W-1:0]    w,
  output logic [gfv_pkg::ROOT_W-1:0] root
);
  import gfv_pkg::*;

  // Remainder and partial root after each resolved bit
  logic [W_W-1:0]    rem_s  [1:ROOT_W];
  logic [ROOT_W-1:0] root_s [1:ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_step
    localparam int B = ROOT_W - 1 - j;
    logic [W_W-1:0]    rem_cur;
    logic [ROOT_W-1:0] root_cur;
    logic [W_W+2:0]    trial;
    logic [W_W+2:0]    rem_ext;
    logic              take;

    if (j == 0) begin : g_first
      assign rem_cur  = w;
      assign root_cur = '0;
    end else begin : g_next
      assign rem_cur  = rem_s[j];
      assign root_cur = root_s[j];
    end

    // Trial subtrahend (2*root + 2^B) * 2^B
    assign trial   = ((W_W+3)'(root_cur) << (B + 1)) | ((W_W+3)'(1) << (2 * B));
    assign rem_ext = (W_W+3)'(rem_cur);
    assign take    = rem_ext >= trial;

    // Resolve one root bit per stage
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[j+1]  <= take ? rem_cur - trial[W_W-1:0] : rem_cur;
        root_s[j+1] <= take ? (root_cur | (ROOT_W'(1) << B)) : root_cur;
      end
    end
  end

  assign root = root_s[ROOT_W];

endmodule

[test/tb_top.sv]
module tb_top;
  import gfv_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int GAP_MAX    = 18;
  localparam logic [63:0] PRESSURE_SAT = 64'h7FFF_FFFF_FFFF;

  typedef struct {
    logic signed [GRAD_W-1:0] g [9];
    logic [P_W-1:0]           pressure;
    logic [FRAC_W-1:0]        fraction;
  } cell_t;

  typedef struct {
    logic [P_W-1:0] viscosity;
    logic           limited;
  } visc_res_t;

  logic clk;
  logic rst;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [P_W-1:0] cfg_data;

  gfv_cell_if grad ();
  gfv_visc_if visc ();

  granular_friction_viscosity_top u_top (
    .clk(clk), .rst(rst), .grad(grad.sink), .visc(visc.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the configuration registers
  logic [FRAC_W-1:0] friction_frac;
  logic [FRAC_W-1:0] packing_frac;
  logic [SIN_W-1:0]  sin_phi;
  logic [P_W-1:0]    visc_limit;

  visc_res_t pending_visc [$];
  int mismatches;
  int idle_cycles;
  int out_stall;
  bit quiet;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [127:0] square_mag(logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    return {64'd0, m} * {64'd0, m};
  endfunction

  // Compute the expected viscosity of one cell from the shadow registers
  function automatic visc_res_t predict_viscosity(cell_t c);
    logic signed [63:0] ux, uy, uz, vx, vy, vz, wx, wy, wz;
    logic [127:0] dsum, xsum, wsum, num, den, q;
    logic [63:0] root, cand, pf, p, an2, n, d;
    visc_res_t res;
    res.viscosity = '0;
    res.limited = 1'b0;
    ux = c.g[0]; uy = c.g[1]; uz = c.g[2];
    vx = c.g[3]; vy = c.g[4]; vz = c.g[5];
    wx = c.g[6]; wy = c.g[7]; wz = c.g[8];
    if (c.fraction > friction_frac) begin
      if (DIMENSIONS == 3) begin
        dsum = square_mag(2 * ux - vy - wz) + square_mag(2 * vy - ux - wz)
             + square_mag(2 * wz - ux - vy);
        xsum = square_mag(uz + wx) + square_mag(uy + vx) + square_mag(wy + vz);
      end else begin
        dsum = square_mag(2 * ux - vy) + square_mag(2 * vy - ux);
        xsum = square_mag(uy + vx);
      end
      wsum = ((dsum << 1) + xsum * 128'd9) << 25;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (wsum >= {64'd0, cand} * {64'd0, cand}) root = cand;
      end
      // Frictional pressure, saturated at or above packing
      if (c.fraction >= packing_frac) begin
        pf = PRESSURE_SAT;
      end else begin
        n = 64'(c.fraction) - 64'(friction_frac);
        d = 64'(packing_frac) - 64'(c.fraction);
        an2 = 64'(c.fraction) * n * n;
        num = {64'd0, an2} << 48;
        den = {64'd0, d} * {64'd0, d} * {64'd0, d} * {64'd0, d} * {64'd0, d} * 128'd10;
        q = num / den;
        pf = (q > {64'd0, PRESSURE_SAT}) ? PRESSURE_SAT : q[63:0];
      end
      p = (64'(c.pressure) > pf) ? 64'(c.pressure) : pf;
      if (root == 0) begin
        res.viscosity = visc_limit;
        res.limited = 1'b1;
      end else begin
        q = ({64'd0, p * 64'(sin_phi)} * 128'd12288) / {64'd0, root};
        if (q > {81'd0, visc_limit}) begin
          res.viscosity = visc_limit;
          res.limited = 1'b1;
        end else begin
          res.viscosity = q[P_W-1:0];
        end
      end
    end
    return res;
  endfunction

  // Drive one cell beat after a random gap; queue its result on acceptance
  task automatic send_cell(cell_t c);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
    @(negedge clk);
    if (gap > 0) begin
      grad.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    grad.valid = 1'b1;
    grad.du_dx = c.g[0]; grad.du_dy = c.g[1]; grad.du_dz = c.g[2];
    grad.dv_dx = c.g[3]; grad.dv_dy = c.g[4]; grad.dv_dz = c.g[5];
    grad.dw_dx = c.g[6]; grad.dw_dy = c.g[7]; grad.dw_dz = c.g[8];
    grad.granular_pressure = c.pressure;
    grad.solid_fraction = c.fraction;
    @(posedge clk);
    while (!grad.ready) @(posedge clk);
    pending_visc.push_back(predict_viscosity(c));
  endtask

  // Lower valid and wait until every queued result has arrived
  task automatic drain();
    @(negedge clk);
    grad.valid = 1'b0;
    while (pending_visc.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [P_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_FRICTION_FRACTION:  friction_frac = value[FRAC_W-1:0];
      CFG_PACKING_FRACTION:   packing_frac = value[FRAC_W-1:0];
      CFG_SIN_FRICTION_ANGLE: sin_phi = value[SIN_W-1:0];
      default:                visc_limit = value;
    endcase
  endtask

  task automatic set_config(int ff, int ap, int sn, logic [P_W-1:0] lim);
    write_reg(CFG_FRICTION_FRACTION, P_W'(ff));
    write_reg(CFG_PACKING_FRACTION, P_W'(ap));
    write_reg(CFG_SIN_FRICTION_ANGLE, P_W'(sn));
    write_reg(CFG_VISCOSITY_LIMIT, lim);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [GRAD_W-1:0] rand_grad();
    case ($urandom_range(0, 4))
      0:       return GRAD_W'(rand64());
      1:       return GRAD_W'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      2:       return GRAD_W'($signed($urandom_range(0, 1 << 13)) - (1 << 12));
      3:       return GRAD_W'($signed($urandom_range(0, 1 << 29)) - (1 << 28));
      default: return '0;
    endcase
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    int lo, hi;
    bit flat;
    flat = ($urandom_range(0, 9) == 0);
    foreach (c.g[i]) c.g[i] = flat ? '0 : rand_grad();
    case ($urandom_range(0, 3))
      0:       c.pressure = P_W'(rand64());
      1:       c.pressure = P_W'($urandom_range(0, 1 << 24));
      2:       c.pressure = P_W'($urandom);
      default: c.pressure = '0;
    endcase
    // Bias the fraction into the frictional band most of the time
    lo = (friction_frac > 200) ? friction_frac - 200 : 0;
    hi = (packing_frac < 65335) ? packing_frac + 200 : 65535;
    if (hi < lo) hi = lo + 400 > 65535 ? 65535 : lo + 400;
    if ($urandom_range(0, 3) != 0) c.fraction = FRAC_W'($urandom_range(lo, hi));
    else c.fraction = FRAC_W'($urandom);
    return c;
  endfunction

  function automatic cell_t make_cell(logic signed [GRAD_W-1:0] gv, logic [P_W-1:0] p,
                                      logic [FRAC_W-1:0] a);
    cell_t c;
    foreach (c.g[i]) c.g[i] = gv;
    c.pressure = p;
    c.fraction = a;
    return c;
  endfunction

  task automatic test_directed();
    cell_t c;
    logic signed [GRAD_W-1:0] gmax, gmin;
    gmax = {1'b0, {(GRAD_W-1){1'b1}}};
    gmin = {1'b1, {(GRAD_W-1){1'b0}}};
    // zero shear saturates to the limit
    send_cell(make_cell('0, 47'd1000, 16'd40000));
    // fraction at and below friction onset gives zero
    send_cell(make_cell(48'sd65536, 47'd1000, 16'd39321));
    send_cell(make_cell(48'sd65536, '1, 16'd0));
    // fraction at and above packing saturates the pressure
    send_cell(make_cell(48'sd65536, '0, 16'd41943));
    send_cell(make_cell(48'sd65536, '0, 16'hFFFF));
    // full-scale gradients of both signs
    c = make_cell(gmax, '1, 16'd40000);
    c.g[4] = gmin; c.g[8] = gmin; c.g[1] = gmax; c.g[3] = gmax;
    send_cell(c);
    c = make_cell(gmin, '1, 16'd41000);
    c.g[0] = gmax; c.g[2] = gmin; c.g[6] = gmin;
    send_cell(c);
    send_cell(make_cell(gmax, '0, 16'd39322));
    send_cell(make_cell(gmin, '0, 16'd39322));
    // moderate shear, unclamped range
    c = make_cell('0, 47'd655360, 16'd39400);
    c.g[0] = 48'sd6553600; c.g[1] = -48'sd3276800; c.g[5] = 48'sd65536;
    send_cell(c);
    c = make_cell('0, '0, 16'd41900);
    c.g[0] = gmax; c.g[4] = gmin; c.g[7] = 48'sd12345;
    send_cell(c);
    for (int i = 0; i < 9; i++) begin
      c = make_cell('0, 47'd65536, 16'd40000);
      c.g[i] = (i % 2) ? gmin : gmax;
      send_cell(c);
    end
    drain();
  endtask

  task automatic test_config_extremes();
    logic [P_W-1:0] lim_max;
    lim_max = '1;
    set_config(0, 65535, 65536, lim_max);
    send_cell(make_cell(48'sd1, '1, 16'd1));
    send_cell(make_cell(48'sd1000, 47'd1, 16'hFFFF));
    send_cell(make_cell(48'sd100, '0, 16'd0));
    send_cell(make_cell('0, '0, 16'd5));
    drain();
    set_config(65535, 0, 0, '0);
    send_cell(make_cell(48'sd1, '1, 16'hFFFF));
    send_cell(make_cell('0, '1, 16'd100));
    drain();
    set_config(100, 200, 65536, 47'd1);
    send_cell(make_cell(48'sd7, '1, 16'd150));
    send_cell(make_cell(48'sd7, '0, 16'd199));
    drain();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_cell(rand_cell());
    end
    quiet = 1'b0;
    drain();
  endtask

  task automatic test_random_configs();
    int ff, ap;
    set_config(FRICTION_FRACTION_RST, PACKING_FRACTION_RST, SIN_FRICTION_ANGLE_RST,
               VISCOSITY_LIMIT_RST);
    test_random(200);
    set_config(0, 65535, 65536, '1);
    test_random(120);
    for (int k = 0; k < 4; k++) begin
      ff = $urandom_range(0, 60000);
      ap = $urandom_range(ff, 65535);
      set_config(ff, ap, $urandom_range(0, 65536), P_W'(rand64()) >> $urandom_range(0, 30));
      test_random(100);
    end
    set_config(65535, 65535, 0, '0);
    test_random(30);
  endtask

  // Result side: draw a stall per beat, compare each beat with the oldest prediction
  always @(negedge clk) begin
    if (rst) begin
      visc.ready = 1'b0;
    end else if (out_stall > 0) begin
      visc.ready = 1'b0;
      out_stall--;
    end else begin
      visc.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    visc_res_t exp_res;
    if (!rst && visc.valid && visc.ready) begin
      out_stall = quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (pending_visc.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: viscosity %0d limited %0b",
                   visc.friction_viscosity, visc.was_limited);
      end else begin
        exp_res = pending_visc.pop_front();
        if (visc.friction_viscosity !== exp_res.viscosity ||
            visc.was_limited !== exp_res.limited) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: viscosity exp %0d got %0d, limited exp %0b got %0b",
                     exp_res.viscosity, visc.friction_viscosity,
                     exp_res.limited, visc.was_limited);
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((grad.valid && grad.ready) || (visc.valid && visc.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_FRICTION_FRACTION;
    cfg_data = '0;
    visc.ready = 1'b0;
    grad.valid = 1'b0;
    grad.du_dx = '0; grad.du_dy = '0; grad.du_dz = '0;
    grad.dv_dx = '0; grad.dv_dy = '0; grad.dv_dz = '0;
    grad.dw_dx = '0; grad.dw_dy = '0; grad.dw_dz = '0;
    grad.granular_pressure = '0;
    grad.solid_fraction = '0;
    friction_frac = FRICTION_FRACTION_RST;
    packing_frac = PACKING_FRACTION_RST;
    sin_phi = SIN_FRICTION_ANGLE_RST;
    visc_limit = VISCOSITY_LIMIT_RST;
    mismatches = 0;
    idle_cycles = 0;
    out_stall = 0;
    quiet = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_config_extremes();
    test_random_configs();
    repeat (N_STG + 20) @(posedge clk);
    if (mismatches == 0 && pending_visc.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
